// ===== sv/fbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// fbfl_pkg
// Shared widths, codes and controller/datapath interface types for the
// fixed-size block free-list pool.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int ADDR_W   = 48;  // buffer byte address
  localparam int BSIZE_W  = 25;  // block size register
  localparam int CNT_W    = 11;  // block counts
  localparam int BYTES_W  = 35;  // byte totals
  localparam int PROD_W   = BSIZE_W + CNT_W;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_BLOCKS = 1024;

  localparam logic [ADDR_W-1:0]  RST_POOL_BASE    = '0;
  localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE   = BSIZE_W'(4096);
  localparam logic [CNT_W-1:0]   RST_TOTAL_BLOCKS = '0;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET   = 2'd0,
    KIND_PUT   = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_BASE    = 2'd0,
    REG_BLOCK_SIZE   = 2'd1,
    REG_TOTAL_BLOCKS = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FLUSH = 2'd1,
    S_CALC  = 2'd2,
    S_DONE  = 2'd3
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    pop;
    logic    push;
    logic    flush_start;
    logic    flush_step;
    logic    flush_end;
    logic    calc;
    logic    load_out;
    logic    use_rd;
    status_t status;
  } fbfl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic flush_done;
    logic out_free;
  } fbfl_sts_t;

endpackage

// ===== sv/fbfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbfl_ctrl
// Sequencer for the free-list pool: decodes each request, drives the
// datapath through pop/push/flush, byte-count and result-load steps.
// ----------------------------------------------------------------------------
module fbfl_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fbfl_pkg::KIND_W-1:0]  kind,
  input  fbfl_pkg::fbfl_sts_t          sts,
  output fbfl_pkg::fbfl_cmd_t          cmd
);
  import fbfl_pkg::*;

  state_t  state, state_next;
  status_t status_q, status_next;
  logic    use_rd_q, use_rd_next;
  logic    accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      status_q <= STAT_OK;
      use_rd_q <= 1'b0;
    end else begin
      state    <= state_next;
      status_q <= status_next;
      use_rd_q <= use_rd_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (kind_t'(kind) == KIND_FLUSH) ? S_FLUSH : S_CALC;
        end
      end
      S_FLUSH: begin
        if (sts.flush_done) state_next = S_CALC;
      end
      S_CALC: state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.status  = status_q;
    cmd.use_rd  = use_rd_q;
    status_next = status_q;
    use_rd_next = use_rd_q;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          status_next = STAT_OK;
          use_rd_next = 1'b0;
          unique case (kind_t'(kind))
            KIND_GET: begin
              if (sts.empty) begin
                status_next = STAT_EMPTY;
              end else begin
                cmd.pop     = 1'b1;
                use_rd_next = 1'b1;
              end
            end
            KIND_PUT: begin
              if (sts.full) status_next = STAT_FULL;
              else          cmd.push    = 1'b1;
            end
            KIND_FLUSH: cmd.flush_start = 1'b1;
            KIND_NONE:  ;
          endcase
        end
      end
      S_FLUSH: begin
        if (sts.flush_done) cmd.flush_end  = 1'b1;
        else                cmd.flush_step = 1'b1;
      end
      S_CALC: cmd.calc = 1'b1;
      S_DONE: cmd.load_out = sts.out_free;
    endcase
  end

endmodule

// ===== sv/fbfl_dp.sv =====
// ----------------------------------------------------------------------------
// fbfl_dp
// Datapath: configuration registers, free-list stack memory and count,
// flush address generator, byte-count multipliers and result register.
// ----------------------------------------------------------------------------
module fbfl_dp #(
  parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::ADDR_W-1:0]     cfg_data,
  input  logic [fbfl_pkg::ADDR_W-1:0]     buffer_address,
  input  fbfl_pkg::fbfl_cmd_t             cmd,
  output fbfl_pkg::fbfl_sts_t             sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fbfl_pkg::ADDR_W-1:0]     granted_address,
  output logic [fbfl_pkg::STAT_W-1:0]     status,
  output logic [fbfl_pkg::CNT_W-1:0]      free_buffers,
  output logic [fbfl_pkg::CNT_W-1:0]      used_buffers,
  output logic [fbfl_pkg::BYTES_W-1:0]    free_bytes,
  output logic [fbfl_pkg::BYTES_W-1:0]    used_bytes
);
  import fbfl_pkg::*;

  localparam int IDX_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_MAX  = (1 << CNT_W) - 1;
  localparam int MAX_CAP  = (MAX_BLOCKS > CNT_MAX) ? CNT_MAX : MAX_BLOCKS;

  logic [ADDR_W-1:0]  pool_base;
  logic [BSIZE_W-1:0] block_size;
  logic [CNT_W-1:0]   total_blocks;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   blocks;
  logic [CNT_W-1:0]   fptr;
  logic [ADDR_W-1:0]  faddr;

  logic [ADDR_W-1:0]  mem [MAX_BLOCKS];
  logic [ADDR_W-1:0]  rd_data;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_idx;
  logic [ADDR_W-1:0]  wr_data;
  logic [IDX_W-1:0]   pop_idx;

  logic [CNT_W-1:0]   used_q;
  logic [PROD_W-1:0]  free_prod;
  logic [PROD_W-1:0]  used_prod;
  logic [CNT_W-1:0]   used_calc;

  // effective pool size, capped by the store depth and the largest count
  assign blocks = (total_blocks < CNT_W'(MAX_CAP)) ? total_blocks : CNT_W'(MAX_CAP);

  assign sts.empty      = (count == '0);
  assign sts.full       = (count >= blocks);
  assign sts.flush_done = (fptr == blocks);
  assign sts.out_free   = !out_valid || out_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base    <= RST_POOL_BASE;
      block_size   <= RST_BLOCK_SIZE;
      total_blocks <= RST_TOTAL_BLOCKS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POOL_BASE:    pool_base    <= cfg_data;
        REG_BLOCK_SIZE:   block_size   <= cfg_data[BSIZE_W-1:0];
        REG_TOTAL_BLOCKS: total_blocks <= cfg_data[CNT_W-1:0];
        default:          ;
      endcase
    end
  end

  // stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      priority if (cmd.pop)       count <= count - CNT_W'(1);
      else if (cmd.push)          count <= count + CNT_W'(1);
      else if (cmd.flush_end)     count <= blocks;
    end
  end

  // flush address walk: base, base + size, base + 2 size, ...
  always_ff @(posedge clk) begin
    if (cmd.flush_start) begin
      fptr  <= '0;
      faddr <= pool_base;
    end else if (cmd.flush_step) begin
      fptr  <= fptr + CNT_W'(1);
      faddr <= faddr + ADDR_W'(block_size);
    end
  end

  // free store
  assign mem_we  = cmd.push || cmd.flush_step;
  assign wr_idx  = cmd.push ? IDX_W'(count) : IDX_W'(fptr);
  assign wr_data = cmd.push ? buffer_address : faddr;
  assign pop_idx = IDX_W'(count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) rd_data <= mem[pop_idx];
  end

  // buffer and byte counts
  assign used_calc = (blocks > count) ? (blocks - count) : '0;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      used_q    <= used_calc;
      free_prod <= PROD_W'(block_size) * PROD_W'(count);
      used_prod <= PROD_W'(block_size) * PROD_W'(used_calc);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      granted_address <= cmd.use_rd ? rd_data : '0;
      status          <= cmd.status;
      free_buffers    <= count;
      used_buffers    <= used_q;
      free_bytes      <= (free_prod[PROD_W-1:BYTES_W] != '0) ? '1 : free_prod[BYTES_W-1:0];
      used_bytes      <= (used_prod[PROD_W-1:BYTES_W] != '0) ? '1 : used_prod[BYTES_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("pop from empty free list");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> count < blocks)
    else $error("push onto full free list");

  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_step |-> fptr < blocks)
    else $error("flush write beyond pool");

  a_flush_count: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_end |=> count == $past(blocks))
    else $error("flush left wrong free count");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");
`endif

endmodule

// ===== sv/fixed_block_free_list_pool_core.sv =====
// ----------------------------------------------------------------------------
// fixed_block_free_list_pool_core
// Fixed-size buffer pool kept as a last-in-first-out free list.
// ----------------------------------------------------------------------------
// Each request (kind: get, put, flush) gives exactly one result carrying the
// granted address, a status code and the free/used buffer and byte totals.
// Get, put and unknown requests are handled one request at a time: the
// request is decoded and the stack accessed (the free-store read is
// registered), then the block-size multiplies of the byte totals are done,
// then the output register is loaded. A flush rewrites the store one entry
// per cycle through its single write port. The output register lets the
// next request be taken while the previous result waits for out_ready.
// The free store has no reset: issue a flush after configuring the pool and
// before the first get. A configuration write lands on the edge it is seen,
// whatever the sequencer is doing, so write the registers only while no
// request is in flight.
module fixed_block_free_list_pool_core #(
  parameter int MAX_BLOCKS = fbfl_pkg::DEF_MAX_BLOCKS
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbfl_pkg::ADDR_W-1:0]     cfg_data,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fbfl_pkg::KIND_W-1:0]     kind,
  input  logic [fbfl_pkg::ADDR_W-1:0]     buffer_address,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fbfl_pkg::ADDR_W-1:0]     granted_address,
  output logic [fbfl_pkg::STAT_W-1:0]     status,
  output logic [fbfl_pkg::CNT_W-1:0]      free_buffers,
  output logic [fbfl_pkg::CNT_W-1:0]      used_buffers,
  output logic [fbfl_pkg::BYTES_W-1:0]    free_bytes,
  output logic [fbfl_pkg::BYTES_W-1:0]    used_bytes
);
  import fbfl_pkg::*;

  fbfl_cmd_t cmd;   // sequencer commands
  fbfl_sts_t sts;   // datapath status

  // request decode and step sequencing
  fbfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stack memory, counters, flush walk, byte math and result register
  fbfl_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .buffer_address  (buffer_address),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .granted_address (granted_address),
    .status          (status),
    .free_buffers    (free_buffers),
    .used_buffers    (used_buffers),
    .free_bytes      (free_bytes),
    .used_bytes      (used_bytes)
  );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the fixed-size block free-list pool against a cycle-free model of
// its stack, counters and byte totals, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import fbfl_pkg::*;

  localparam int POOL_DEPTH = DEF_MAX_BLOCKS;
  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

  // one request as queued for the driver
  typedef struct packed {
    kind_t             op;
    logic [ADDR_W-1:0] addr;
  } pool_req_t;

  // one answer of the pool, field for field as on the result ports
  typedef struct packed {
    logic [ADDR_W-1:0]  granted;
    status_t            stat;
    logic [CNT_W-1:0]   free_bufs;
    logic [CNT_W-1:0]   used_bufs;
    logic [BYTES_W-1:0] free_byte_cnt;
    logic [BYTES_W-1:0] used_byte_cnt;
  } pool_answer_t;

  // dut ports, every input known from time zero
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    kind = '0;
  logic [ADDR_W-1:0]    buffer_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ADDR_W-1:0]    granted_address;
  logic [STAT_W-1:0]    status;
  logic [CNT_W-1:0]     free_buffers;
  logic [CNT_W-1:0]     used_buffers;
  logic [BYTES_W-1:0]   free_bytes;
  logic [BYTES_W-1:0]   used_bytes;

  // shadow copy of the pool: registers, free stack and its depth
  logic [ADDR_W-1:0]  shadow_base  = RST_POOL_BASE;
  logic [BSIZE_W-1:0] shadow_bsize = RST_BLOCK_SIZE;
  logic [CNT_W-1:0]   shadow_total = RST_TOTAL_BLOCKS;
  logic [ADDR_W-1:0]  shadow_store [POOL_DEPTH];
  int unsigned        shadow_count = 0;

  pool_req_t    request_q[$];  // requests waiting for the driver
  pool_answer_t answer_q[$];   // answers owed by the pool, oldest first

  int unsigned send_idle_pct  = 33;
  int unsigned recv_stall_pct = 50;
  int unsigned mismatches     = 0;

  fixed_block_free_list_pool_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .buffer_address  (buffer_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .granted_address (granted_address),
    .status          (status),
    .free_buffers    (free_buffers),
    .used_buffers    (used_buffers),
    .free_bytes      (free_bytes),
    .used_bytes      (used_bytes)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block size times a buffer count, clipped to the 35-bit byte field
  function automatic logic [BYTES_W-1:0] byte_span(int unsigned count);
    logic [63:0] prod;
    prod = 64'(shadow_bsize) * 64'(count);
    return (prod > 64'(BYTES_MAX)) ? BYTES_MAX : prod[BYTES_W-1:0];
  endfunction

  // applies one request to the shadow pool and returns the answer it owes
  function automatic pool_answer_t pool_answer(kind_t op, logic [ADDR_W-1:0] addr);
    pool_answer_t ans;
    int unsigned  blocks;
    int unsigned  used;
    logic [63:0]  fill_addr;
    ans = '0;
    ans.stat = STAT_OK;
    // the pool never grows past the store depth
    blocks = (shadow_total < POOL_DEPTH) ? shadow_total : POOL_DEPTH;
    case (op)
      KIND_GET: begin
        if (shadow_count > 0) begin
          shadow_count--;
          ans.granted = shadow_store[shadow_count];
        end else begin
          ans.stat = STAT_EMPTY;
        end
      end
      KIND_PUT: begin
        // a full stack rejects the push and keeps its state
        if (shadow_count >= blocks) begin
          ans.stat = STAT_FULL;
        end else begin
          shadow_store[shadow_count] = addr;
          shadow_count++;
        end
      end
      KIND_FLUSH: begin
        // addresses wrap at 48 bits
        for (int unsigned i = 0; i < blocks; i++) begin
          fill_addr = 64'(shadow_base) + 64'(i) * 64'(shadow_bsize);
          shadow_store[i] = fill_addr[ADDR_W-1:0];
        end
        shadow_count = blocks;
      end
      default: ;  // unknown kind leaves the pool alone
    endcase
    // a pool shrunk below the free count reports zero in use
    used = (blocks > shadow_count) ? blocks - shadow_count : 0;
    ans.free_bufs     = CNT_W'(shadow_count);
    ans.used_bufs     = CNT_W'(used);
    ans.free_byte_cnt = byte_span(shadow_count);
    ans.used_byte_cnt = byte_span(used);
    return ans;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // request driver: valid goes up without looking at ready and holds
  // until the transfer; the answer is predicted at the transfer edge
  always @(posedge clk) begin : request_drive
    pool_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        answer_q.push_back(pool_answer(kind_t'(kind), buffer_address));
      end
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_q.pop_front();
          in_valid       <= 1'b1;
          kind           <= nxt.op;
          buffer_address <= nxt.addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: each transfer is held against the oldest answer owed
  always @(posedge clk) begin : result_check
    pool_answer_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          check_field("granted_address", 64'(want.granted), 64'(granted_address));
          check_field("status", 64'(want.stat), 64'(status));
          check_field("free_buffers", 64'(want.free_bufs), 64'(free_buffers));
          check_field("used_buffers", 64'(want.used_bufs), 64'(used_buffers));
          check_field("free_bytes", 64'(want.free_byte_cnt), 64'(free_bytes));
          check_field("used_bytes", 64'(want.used_byte_cnt), 64'(used_bytes));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // stimulus tasks run from the sequence below; they always return
  // on a falling edge so queue updates never share an edge with the driver
  task automatic post_request(kind_t op, logic [ADDR_W-1:0] addr);
    pool_req_t req;
    req.op   = op;
    req.addr = addr;
    request_q.push_back(req);
  endtask

  // sender holds off until the pool has answered everything
  task automatic wait_pool_quiet();
    @(negedge clk);
    while (request_q.size() != 0 || in_valid || answer_q.size() != 0) @(negedge clk);
  endtask

  // register write, only ever issued while the pool is quiet
  task automatic write_cfg(cfg_reg_t idx, logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_POOL_BASE:    shadow_base  = value;
      REG_BLOCK_SIZE:   shadow_bsize = value[BSIZE_W-1:0];
      REG_TOTAL_BLOCKS: shadow_total = value[CNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_pool(logic [ADDR_W-1:0] base, logic [BSIZE_W-1:0] bsize,
                          logic [CNT_W-1:0] total);
    write_cfg(REG_POOL_BASE, base);
    write_cfg(REG_BLOCK_SIZE, ADDR_W'(bsize));
    write_cfg(REG_TOTAL_BLOCKS, ADDR_W'(total));
  endtask

  // random request with a realistic mix: mostly gets and puts, a few
  // flushes and unknown kinds; half the puts hand back a pool address
  task automatic post_random_request();
    int unsigned       pick;
    logic [ADDR_W-1:0] addr;
    logic [63:0]       slot_addr;
    pick = $urandom_range(99);
    if ($urandom_range(1) == 0) begin
      addr = ADDR_W'({$urandom(), $urandom()});
    end else begin
      slot_addr = 64'(shadow_base) +
                  64'($urandom_range(shadow_total)) * 64'(shadow_bsize);
      addr = slot_addr[ADDR_W-1:0];
    end
    if (pick < 45)      post_request(KIND_GET, addr);
    else if (pick < 90) post_request(KIND_PUT, addr);
    else if (pick < 95) post_request(KIND_FLUSH, addr);
    else                post_request(KIND_NONE, addr);
  endtask

  initial begin : sequence_run
    logic [ADDR_W-1:0]  base;
    logic [BSIZE_W-1:0] bsize;
    logic [CNT_W-1:0]   total;
    int unsigned        phases;
    int unsigned        per_phase;

    phases    = 40;
    per_phase = 35;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed part ---
    // reset registers, empty pool: get finds nothing, put finds no room,
    // flush of a zero-block pool leaves nothing free
    post_request(KIND_GET, '0);
    post_request(KIND_PUT, ADDR_MAX);
    post_request(KIND_NONE, ADDR_MAX);
    post_request(KIND_FLUSH, '0);
    wait_pool_quiet();

    // three blocks near the top of the address space so the flush wraps;
    // drain to empty, refill with extreme addresses, overfill once
    set_pool(48'hFFFF_FFFF_E000, 25'h100_0000, 11'd3);
    post_request(KIND_FLUSH, '0);
    repeat (4) post_request(KIND_GET, '0);
    post_request(KIND_PUT, ADDR_MAX);
    post_request(KIND_PUT, '0);
    post_request(KIND_PUT, 48'h5555_5555_5555);
    post_request(KIND_PUT, 48'hAAAA_AAAA_AAAA);
    post_request(KIND_NONE, '0);
    post_request(KIND_GET, '0);
    wait_pool_quiet();

    // shrink the pool under the free count: used saturates at zero
    write_cfg(REG_TOTAL_BLOCKS, ADDR_W'(11'd1));
    post_request(KIND_PUT, 48'h0000_0000_1000);
    post_request(KIND_GET, '0);
    post_request(KIND_GET, '0);
    wait_pool_quiet();

    // zero block size with a count above the store depth
    set_pool(48'h1234_5678_9ABC, '0, 11'h7FF);
    post_request(KIND_FLUSH, '0);
    post_request(KIND_GET, '0);
    post_request(KIND_PUT, 48'hFFFF_0000_FFFF);
    wait_pool_quiet();

    // --- random part ---
    for (int unsigned p = 0; p < phases; p++) begin
      // idling profile by thirds of the run
      if (p < phases / 3) begin
        send_idle_pct  = 33;
        recv_stall_pct = 50;
      end else if (p < 2 * phases / 3) begin
        send_idle_pct  = 50;
        recv_stall_pct = 33;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      // mostly small pools; a few at full depth or beyond it
      if (p == 5 || p == 20)   total = 11'd1024;
      else if (p == 33)        total = 11'h7FF;
      else if (p % 9 == 8)     total = '0;
      else                     total = CNT_W'($urandom_range(24, 1));

      case ($urandom_range(9))
        0:       bsize = '0;
        1:       bsize = 25'd1;
        2:       bsize = 25'h100_0000;
        3:       bsize = 25'h1FF_FFFF;
        default: bsize = BSIZE_W'($urandom_range(25'h1FF_FFFF) >> $urandom_range(24));
      endcase
      if (p == 5) bsize = 25'h1FF_FFFF;  // largest byte totals

      if ($urandom_range(3) == 0) base = ADDR_MAX - ADDR_W'($urandom_range(255));
      else                        base = ADDR_W'({$urandom(), $urandom()});

      set_pool(base, bsize, total);

      // usually start from a fresh list; otherwise keep the old stack,
      // which may now be larger than the pool
      if ($urandom_range(4) != 0) post_request(KIND_FLUSH, '0);

      for (int unsigned n = 0; n < per_phase; n++) begin
        post_random_request();
        // mid-phase hold-off until the pool has answered everything
        if (n == per_phase / 2) wait_pool_quiet();
      end
      wait_pool_quiet();
    end

    // let any stray result show up before the verdict
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS fixed_block_free_list_pool_core");
    end else begin
      $display("FAIL fixed_block_free_list_pool_core");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("FAIL fixed_block_free_list_pool_core");
    $finish;
  end

endmodule
